>>> hdl/packet_classifier_tree_beacon_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros for the tree beacon packet classifier.
// Shared helpers so that every check reports the same way.
// -----------------------------------------------------------------------------
`ifndef PACKET_CLASSIFIER_TREE_BEACON_MACROS_SVH
`define PACKET_CLASSIFIER_TREE_BEACON_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PCTB_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("pctb assertion failed");

// Next-cycle implication, checked out of reset.
`define PCTB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("pctb assertion failed");

`endif

>>> hdl/pctb_pkg.sv
// -----------------------------------------------------------------------------
// pctb_pkg
// Types and codes shared by the tree beacon packet classifier.
// -----------------------------------------------------------------------------
package pctb_pkg;

	localparam int CfgIdxW  = 8;
	localparam int CfgDataW = 16;

	// Configuration register indexes.
	typedef enum logic [CfgIdxW-1:0] {
		REG_MIN_SIGNAL       = 8'd0,
		REG_NETWORK_ID       = 8'd1,
		REG_NODE_ADDRESS     = 8'd2,
		REG_TREE_BEACON_CODE = 8'd3
	} reg_idx_t;

	// Header packet kinds.
	typedef enum logic [3:0] {
		KIND_DATA      = 4'd0,
		KIND_BEACON    = 4'd1,
		KIND_REPORT    = 4'd2,
		KIND_REQUEST   = 4'd3,
		KIND_RESPONSE  = 4'd4,
		KIND_OPEN_PATH = 4'd5,
		KIND_CONFIG    = 4'd6,
		KIND_WEB       = 4'd7
	} kind_t;

	// Result classes.
	typedef enum logic [3:0] {
		CLS_FILTERED   = 4'd0,
		CLS_BEACON     = 4'd1,
		CLS_NOT_FOR_ME = 4'd2,
		CLS_DATA       = 4'd3,
		CLS_RESPONSE   = 4'd4,
		CLS_OPEN_PATH  = 4'd5,
		CLS_CONFIG     = 4'd6,
		CLS_WEB        = 4'd7,
		CLS_REPORT     = 4'd8
	} class_t;

	localparam logic [8:0] VersionSlack = 9'd2;
	localparam logic [8:0] HopStep      = 9'd1;
	localparam logic [7:0] NoPathHops   = 8'd255;

	typedef struct packed {
		logic [7:0]  signal_strength;
		logic [7:0]  packet_network;
		logic [3:0]  packet_kind;
		logic [15:0] next_hop_address;
		logic [15:0] source_address;
		logic [7:0]  beacon_kind;
		logic [7:0]  beacon_version;
		logic [7:0]  beacon_depth;
	} rx_item_t;

	typedef struct packed {
		class_t      packet_class;
		logic        send_beacon;
		logic [7:0]  out_version;
		logic [7:0]  out_hops;
		logic [15:0] out_sink;
		logic [15:0] out_parent;
	} res_item_t;

	typedef struct packed {
		logic [7:0]  min_signal;
		logic [7:0]  network_id;
		logic [15:0] node_address;
		logic [7:0]  tree_beacon_code;
	} cfg_regs_t;

	typedef struct packed {
		logic [7:0]  version;
		logic [7:0]  hops;
		logic [15:0] parent;
		logic [7:0]  parent_sig;
		logic [15:0] sink;
	} tree_state_t;

endpackage

>>> hdl/pctb_ifs.sv
// -----------------------------------------------------------------------------
// pctb channel interfaces
// Valid/ready channels for headers, results and register writes.
// -----------------------------------------------------------------------------
interface pctb_rx_if;
	logic               valid;
	logic               ready;
	pctb_pkg::rx_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface pctb_res_if;
	logic                valid;
	logic                ready;
	pctb_pkg::res_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface pctb_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [pctb_pkg::CfgIdxW-1:0]  index;
	logic [pctb_pkg::CfgDataW-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/pctb_tree_update.sv
// -----------------------------------------------------------------------------
// pctb_tree_update
// Filters and classifies one header and works out the next tree state.
// -----------------------------------------------------------------------------
module pctb_tree_update (
	input  pctb_pkg::rx_item_t    item,
	input  pctb_pkg::cfg_regs_t   regs,
	input  pctb_pkg::tree_state_t state_cur,
	output pctb_pkg::tree_state_t state_nxt,
	output pctb_pkg::res_item_t   result
);

	logic                passed;
	logic                is_tree;
	logic                far_older;
	logic                newer;
	logic                shorter;
	logic [8:0]          ver_plus;
	logic [8:0]          depth_plus;
	pctb_pkg::class_t    cls;
	pctb_pkg::class_t    kind_cls;
	logic                send;

	assign ver_plus   = {1'b0, item.beacon_version} + pctb_pkg::VersionSlack;
	assign depth_plus = {1'b0, item.beacon_depth} + pctb_pkg::HopStep;

	assign passed  = (item.signal_strength >= regs.min_signal)
		&& (item.packet_network == regs.network_id);
	assign is_tree = passed && (item.packet_kind == pctb_pkg::KIND_BEACON)
		&& (item.beacon_kind == regs.tree_beacon_code);

	assign far_older = {1'b0, state_cur.version} > ver_plus;
	assign newer     = item.beacon_version > state_cur.version;
	assign shorter   = (item.beacon_version == state_cur.version)
		&& (depth_plus < {1'b0, state_cur.hops});

	always_comb begin
		unique case (item.packet_kind)
			pctb_pkg::KIND_DATA:      kind_cls = pctb_pkg::CLS_DATA;
			pctb_pkg::KIND_RESPONSE:  kind_cls = pctb_pkg::CLS_RESPONSE;
			pctb_pkg::KIND_OPEN_PATH: kind_cls = pctb_pkg::CLS_OPEN_PATH;
			pctb_pkg::KIND_CONFIG:    kind_cls = pctb_pkg::CLS_CONFIG;
			pctb_pkg::KIND_WEB:       kind_cls = pctb_pkg::CLS_WEB;
			default:                  kind_cls = pctb_pkg::CLS_REPORT;
		endcase
	end

	always_comb begin
		priority if (!passed) begin
			cls = pctb_pkg::CLS_FILTERED;
		end else if (item.packet_kind == pctb_pkg::KIND_BEACON) begin
			cls = pctb_pkg::CLS_BEACON;
		end else if (item.next_hop_address == regs.node_address) begin
			cls = kind_cls;
		end else begin
			cls = pctb_pkg::CLS_NOT_FOR_ME;
		end
	end

	always_comb begin
		state_nxt = state_cur;
		send      = 1'b0;
		if (is_tree) begin
			priority if (far_older) begin
				state_nxt.version = item.beacon_version;
			end else if (newer || shorter) begin
				state_nxt.version    = item.beacon_version;
				state_nxt.hops       = depth_plus[7:0];
				state_nxt.parent     = item.source_address;
				state_nxt.parent_sig = item.signal_strength;
				state_nxt.sink       = item.next_hop_address;
				send                 = 1'b1;
			end else begin
				state_nxt = state_cur;
			end
		end
	end

	assign result.packet_class = cls;
	assign result.send_beacon  = send;
	assign result.out_version  = state_nxt.version;
	assign result.out_hops     = state_nxt.hops;
	assign result.out_sink     = state_nxt.sink;
	assign result.out_parent   = state_nxt.parent;

endmodule

>>> hdl/packet_classifier_tree_beacon.sv
// -----------------------------------------------------------------------------
// packet_classifier_tree_beacon
// Filters received headers, tracks the routing tree from tree beacons and
// classifies the remaining packets for this node.
// -----------------------------------------------------------------------------
//  Channel | Direction | Beat carries
//  --------+-----------+------------------------------------------------
//  rx      | in        | one received packet header
//  res     | out       | class, rebroadcast flag and tree state after it
//  cfg     | in        | register index and write data
//
// A header is registered in stage one on acceptance, and its result is then
// registered in the result register, which holds it while res stalls. A new
// header can be taken every cycle while res does not stall; throughput is set
// by the single compare-and-select update of the tree state registers.
// Reset clears the valid flags and the tree state (hop count to 255, meaning no
// path yet) and sets the configuration registers to defaults. When the result
// register is stalled, one more header is still taken into the input register.
// -----------------------------------------------------------------------------
module packet_classifier_tree_beacon (
	input  logic          clk,
	input  logic          arst_n,
	pctb_rx_if.sink       rx,
	pctb_res_if.source    res,
	pctb_cfg_if.sink      cfg
);

	// Configuration registers. The port never stalls; writes to indexes
	// outside the register list are dropped.
	pctb_pkg::cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.min_signal       <= 8'd0;
			regs_q.network_id       <= 8'd1;
			regs_q.node_address     <= 16'd0;
			regs_q.tree_beacon_code <= 8'd1;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				pctb_pkg::REG_MIN_SIGNAL:       regs_q.min_signal       <= cfg.data[7:0];
				pctb_pkg::REG_NETWORK_ID:       regs_q.network_id       <= cfg.data[7:0];
				pctb_pkg::REG_NODE_ADDRESS:     regs_q.node_address     <= cfg.data;
				pctb_pkg::REG_TREE_BEACON_CODE: regs_q.tree_beacon_code <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	// Stage one holds the accepted header. Stage two is the result register.
	// The header moves on whenever the result register is empty or is being
	// drained in the same cycle.
	logic                  valid_s1;
	pctb_pkg::rx_item_t    item_s1;
	logic                  valid_s2;
	pctb_pkg::res_item_t   item_s2;
	logic                  advance;

	assign advance  = valid_s1 && (!valid_s2 || res.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			item_s1 <= rx.item;
		end
	end

	// The tree state changes only when a header moves into the result
	// register, so the next header in stage one always sees the state that
	// the previous header left behind.
	pctb_pkg::tree_state_t state_q;
	pctb_pkg::tree_state_t state_nxt;
	pctb_pkg::res_item_t   result;

	pctb_tree_update u_update (
		.item      (item_s1),
		.regs      (regs_q),
		.state_cur (state_q),
		.state_nxt (state_nxt),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.version    <= 8'd0;
			state_q.hops       <= pctb_pkg::NoPathHops;
			state_q.parent     <= 16'd0;
			state_q.parent_sig <= 8'd0;
			state_q.sink       <= 16'd0;
			valid_s2           <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (!valid_s2 || res.ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s2 <= result;
		end
	end

	assign res.valid = valid_s2;
	assign res.item  = item_s2;

endmodule

>>> hdl/pctb_checker.sv
// -----------------------------------------------------------------------------
// pctb_checker
// Port-level checks on the tree beacon packet classifier.
// -----------------------------------------------------------------------------
`include "packet_classifier_tree_beacon_macros.svh"

module pctb_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                rx_ready,
	input logic                res_valid,
	input logic                res_ready,
	input pctb_pkg::res_item_t res_item
);

	logic res_stall;
	logic res_send;
	logic res_is_beacon;

	assign res_stall     = res_valid && !res_ready;
	assign res_send      = res_valid && res_item.send_beacon;
	assign res_is_beacon = res_item.packet_class == pctb_pkg::CLS_BEACON;

	// A stalled result keeps its beat.
	`PCTB_ASSERT_NEXT(a_res_hold, clk, arst_n, res_stall, res_valid && $stable(res_item))

	// With the result register empty, stage one drains, so headers are taken.
	`PCTB_ASSERT_SAME(a_rx_open, clk, arst_n, !res_valid, rx_ready)

	// Only a tree beacon can ask for a rebroadcast.
	`PCTB_ASSERT_SAME(a_send_beacon, clk, arst_n, res_send, res_is_beacon)

	// A result beat always carries one of the defined classes.
	`PCTB_ASSERT_SAME(a_class_range, clk, arst_n, res_valid, res_item.packet_class <= pctb_pkg::CLS_REPORT)

endmodule

bind packet_classifier_tree_beacon pctb_checker u_pctb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rx_ready  (rx.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_item  (res.item)
);
